### rtl/mpcr_pkg.sv
// ----------------------------------------------------------------------------
// mpcr_pkg
// Shared widths, reset values, codes and types of the meter pulse counter.
// ----------------------------------------------------------------------------
package mpcr_pkg;

  localparam int PERIOD_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int SAMPLE_W    = 10;
  localparam int LOCKOUT_W   = 10;
  localparam int INTERVAL_W  = 27;
  localparam int ELAPSED_W   = 32;
  localparam int PERIOD_W    = 32;
  localparam int PPH_W       = 22;
  localparam int ICOUNT_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 27;

  localparam logic [PPH_W-1:0]      MS_PER_HOUR  = 22'd3600000;
  localparam logic [SAMPLE_W-1:0]   SAMPLE_RST   = 10'd2;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RST  = 10'd25;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 27'd300000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_MS = 2'd0,
    REG_LOCKOUT   = 2'd1,
    REG_INTERVAL  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEVEL_LOW     = 2'd0,
    LEVEL_HIGH    = 2'd1,
    LEVEL_UNKNOWN = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DECIDE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/mpcr_ifs.sv
// ----------------------------------------------------------------------------
// mpcr_ifs
// Valid/ready channels of the meter pulse counter: samples, results, config.
// ----------------------------------------------------------------------------
interface mpcr_sample_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface mpcr_result_if;
  import mpcr_pkg::*;
  logic                valid;
  logic                ready;
  logic                pulse_seen;
  logic                period_valid;
  logic [PERIOD_W-1:0] period_ms;
  logic [PPH_W-1:0]    pulses_per_hour;
  logic                report_seen;
  logic [ICOUNT_W-1:0] interval_count;

  modport source (output valid, output pulse_seen, output period_valid, output period_ms,
                  output pulses_per_hour, output report_seen, output interval_count,
                  input ready);
  modport sink   (input valid, input pulse_seen, input period_valid, input period_ms,
                  input pulses_per_hour, input report_seen, input interval_count,
                  output ready);
endinterface

interface mpcr_cfg_if;
  import mpcr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mpcr_div.sv
// ----------------------------------------------------------------------------
// mpcr_div
// Rate divider: round(3600000 / period), 3600000 for a zero period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpcr_div #(
  parameter int PERIOD_BITS = mpcr_pkg::PERIOD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [PERIOD_BITS-1:0]     divisor,
  output mpcr_pkg::div_status_t      status,
  output logic [mpcr_pkg::PPH_W-1:0] quotient
);
  import mpcr_pkg::*;

  localparam int NUM_W  = ((PERIOD_BITS > PPH_W) ? PERIOD_BITS : PPH_W) + 1;
  localparam int CNT_W  = $clog2(PPH_W);
  localparam int LAST   = PPH_W - 1;

  logic                   busy;
  logic                   loading;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [PERIOD_BITS-1:0] dsr;
  logic [PERIOD_BITS-1:0] rem;
  logic [PPH_W-1:0]       lo;
  logic [PPH_W-1:0]       quo;

  logic [NUM_W-1:0]       num;
  logic [PERIOD_BITS:0]   shifted;
  logic [PERIOD_BITS+1:0] diff;
  logic                   ge;

  always_comb begin
    num     = NUM_W'(MS_PER_HOUR) + NUM_W'(dsr >> 1);
    shifted = {rem, lo[PPH_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    ge      = ~diff[PERIOD_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      loading <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        if (divisor == '0) begin
          quo  <= MS_PER_HOUR;
          done <= 1'b1;
        end else begin
          dsr     <= divisor;
          busy    <= 1'b1;
          loading <= 1'b1;
        end
      end else if (busy && loading) begin
        rem     <= PERIOD_BITS'(num >> PPH_W);
        lo      <= num[PPH_W-1:0];
        cnt     <= '0;
        loading <= 1'b0;
      end else if (busy) begin
        rem <= ge ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
        lo  <= {lo[PPH_W-2:0], 1'b0};
        quo <= {quo[PPH_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(LAST)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

### rtl/meter_pulse_counter_rate_core.sv
// ----------------------------------------------------------------------------
// meter_pulse_counter_rate_core
// Energy meter pulse counter with period, rate and interval count reports.
// ----------------------------------------------------------------------------
// One sample is taken at a time. Each sample runs a bit-serial pass in ST_ADD
// that adds sample_ms to the time since the last pulse and to the interval
// time, and compares the interval time against report_interval_ms in the same
// pass; ST_DECIDE then decides edge, lockout and report. A counted pulse that
// follows an earlier pulse adds the rate divider in ST_DIV (one quotient bit a
// cycle). A finished result sits in an output register, so the next sample is
// taken while it waits.
module meter_pulse_counter_rate_core #(
  parameter int PERIOD_BITS = mpcr_pkg::PERIOD_BITS_DEF,
  parameter int COUNT_BITS  = mpcr_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mpcr_sample_if.sink   sample,
  mpcr_result_if.source result,
  mpcr_cfg_if.sink      cfg
);
  import mpcr_pkg::*;

  localparam int MAXW     = (PERIOD_BITS > ELAPSED_W) ? PERIOD_BITS : ELAPSED_W;
  localparam int CNT_W    = $clog2(MAXW);
  localparam int ADD_LAST = MAXW - 1;
  localparam int PWIDE    = (PERIOD_BITS > PERIOD_W) ? PERIOD_BITS : PERIOD_W;
  localparam int CWIDE    = (COUNT_BITS > ICOUNT_W) ? COUNT_BITS : ICOUNT_W;

  state_t state;
  state_t state_next;

  logic [SAMPLE_W-1:0]   sample_ms;
  logic [LOCKOUT_W-1:0]  lockout_samples;
  logic [INTERVAL_W-1:0] report_interval_ms;

  logic                   level_in;
  level_t                 prev_level;
  logic [LOCKOUT_W-1:0]   lockout_left;
  logic [PERIOD_BITS-1:0] since;
  logic                   seen_before;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [ELAPSED_W-1:0]   elapsed_diff;
  logic [COUNT_BITS-1:0]  pulse_count;
  logic [SAMPLE_W-1:0]    addend;
  logic [INTERVAL_W-1:0]  ivl;
  logic [CNT_W-1:0]       cnt;
  logic                   carry_since;
  logic                   carry_elapsed;
  logic                   borrow;

  logic                st_pulse;
  logic                st_pvalid;
  logic [PERIOD_W-1:0] st_period;
  logic [PPH_W-1:0]    st_pph;
  logic                st_report;
  logic [ICOUNT_W-1:0] st_icount;

  logic                res_valid;
  logic                res_pulse;
  logic                res_pvalid;
  logic [PERIOD_W-1:0] res_period;
  logic [PPH_W-1:0]    res_pph;
  logic                res_report;
  logic [ICOUNT_W-1:0] res_icount;

  logic                   m_bit;
  logic                   i_bit;
  logic                   s_since;
  logic                   s_elapsed;
  logic                   d_elapsed;
  logic [PERIOD_BITS-1:0] p;
  logic [PWIDE-1:0]       p_wide;
  logic                   locked;
  logic                   is_edge;
  logic                   pulse;
  logic                   pvalid;
  logic                   report;
  logic [COUNT_BITS-1:0]  count_after;
  logic [CWIDE-1:0]       count_wide;
  logic                   interval_zero;

  logic                   div_start;
  logic                   res_load;
  div_status_t            div_status;
  logic [PPH_W-1:0]       div_quotient;

  mpcr_div #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (p),
    .status   (div_status),
    .quotient (div_quotient)
  );

  always_comb begin
    m_bit     = addend[0];
    i_bit     = ivl[0];
    s_since   = since[0] ^ m_bit ^ carry_since;
    s_elapsed = elapsed[0] ^ m_bit ^ carry_elapsed;
    d_elapsed = s_elapsed ^ i_bit ^ borrow;

    p       = carry_since ? '1 : since;
    p_wide  = PWIDE'(p);
    locked  = lockout_left != '0;
    is_edge = !locked && ({1'b0, level_in} != prev_level);
    pulse   = is_edge && level_in;
    pvalid  = pulse && seen_before;
    report  = ~borrow;

    count_after   = (pulse && pulse_count != '1) ? pulse_count + 1'b1 : pulse_count;
    count_wide    = CWIDE'(count_after);
    interval_zero = report_interval_ms == '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (cnt == CNT_W'(ADD_LAST)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (pvalid) state_next = ST_DIV;
        else if (pulse || report) state_next = ST_EMIT;
        else state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_status.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_valid || result.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    div_start    = 1'b0;
    res_load     = 1'b0;
    case (state)
      ST_IDLE:   sample.ready = 1'b1;
      ST_DECIDE: div_start = pvalid;
      ST_EMIT:   res_load = !res_valid || result.ready;
      default: ;
    endcase
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_ms          <= SAMPLE_RST;
      lockout_samples    <= LOCKOUT_RST;
      report_interval_ms <= INTERVAL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SAMPLE_MS: sample_ms          <= cfg.data[SAMPLE_W-1:0];
        REG_LOCKOUT:   lockout_samples    <= cfg.data[LOCKOUT_W-1:0];
        REG_INTERVAL:  report_interval_ms <= cfg.data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= LEVEL_UNKNOWN;
      lockout_left <= '0;
      since        <= '0;
      seen_before  <= 1'b0;
      elapsed      <= '0;
      pulse_count  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            level_in      <= sample.level;
            addend        <= sample_ms;
            ivl           <= report_interval_ms;
            cnt           <= '0;
            carry_since   <= 1'b0;
            carry_elapsed <= 1'b0;
            borrow        <= 1'b0;
          end
        end
        ST_ADD: begin
          cnt    <= cnt + 1'b1;
          addend <= {1'b0, addend[SAMPLE_W-1:1]};
          ivl    <= {1'b0, ivl[INTERVAL_W-1:1]};
          if (cnt < PERIOD_BITS) begin
            since       <= {s_since, since[PERIOD_BITS-1:1]};
            carry_since <= (since[0] & m_bit) | (carry_since & (since[0] ^ m_bit));
          end
          if (cnt < ELAPSED_W) begin
            elapsed       <= {s_elapsed, elapsed[ELAPSED_W-1:1]};
            elapsed_diff  <= {d_elapsed, elapsed_diff[ELAPSED_W-1:1]};
            carry_elapsed <= (elapsed[0] & m_bit) | (carry_elapsed & (elapsed[0] ^ m_bit));
            borrow        <= (~s_elapsed & i_bit) | (~(s_elapsed ^ i_bit) & borrow);
          end
        end
        ST_DECIDE: begin
          since       <= pulse ? '0 : p;
          seen_before <= seen_before | pulse;
          if (locked) begin
            lockout_left <= lockout_left - 1'b1;
          end else if (is_edge && !level_in) begin
            lockout_left <= lockout_samples;
          end
          if (is_edge) prev_level <= level_in ? LEVEL_HIGH : LEVEL_LOW;
          pulse_count <= report ? '0 : count_after;
          if (report) elapsed <= interval_zero ? '0 : elapsed_diff;

          st_pulse  <= pulse;
          st_pvalid <= pvalid;
          st_period <= pvalid ? ((p_wide > PWIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : p_wide[PERIOD_W-1:0])
                              : '0;
          st_pph    <= '0;
          st_report <= report;
          st_icount <= report ? ((count_wide > CWIDE'(16'hFFFF)) ? 16'hFFFF
                                                                  : count_wide[ICOUNT_W-1:0])
                              : '0;
        end
        ST_DIV: begin
          if (div_status.done) st_pph <= div_quotient;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid  <= 1'b1;
      res_pulse  <= st_pulse;
      res_pvalid <= st_pvalid;
      res_period <= st_period;
      res_pph    <= st_pph;
      res_report <= st_report;
      res_icount <= st_icount;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid           = res_valid;
  assign result.pulse_seen      = res_pulse;
  assign result.period_valid    = res_pvalid;
  assign result.period_ms       = res_period;
  assign result.pulses_per_hour = res_pph;
  assign result.report_seen     = res_report;
  assign result.interval_count  = res_icount;

`ifndef NO_ASSERTIONS
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.pulse_seen || result.report_seen))
    else $error("result without pulse or report");

  a_period_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.pulse_seen) |-> !result.period_valid)
    else $error("period reported without a pulse");

  a_rate_bounded: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.period_valid) |-> (result.pulses_per_hour <= MS_PER_HOUR))
    else $error("pulses per hour above limit");

  a_div_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_status.done) |=> (state == ST_EMIT))
    else $error("divider result not taken");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_status.busy)
    else $error("divider busy while idle");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the meter pulse counter with period and rate output.
// Samples are queued by a stimulus process and sent by a clocked driver. A
// clocked monitor predicts each result at sample acceptance and compares the
// block's results against it field by field. Runs cover reset defaults, zero
// period and zero interval, shortened intervals, long lockouts, long
// periods, and random pulse trains with flutter under random settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpcr_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 380;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic                pulse_seen;
    logic                period_valid;
    logic [PERIOD_W-1:0] period_ms;
    logic [PPH_W-1:0]    pulses_per_hour;
    logic                report_seen;
    logic [ICOUNT_W-1:0] interval_count;
  } meter_result_t;

  logic clk;
  logic rst;

  mpcr_sample_if smp_if ();
  mpcr_result_if res_if ();
  mpcr_cfg_if    cfg_if ();

  meter_pulse_counter_rate_core u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // meter state as the block should hold it
  logic [SAMPLE_W-1:0]   cur_sample_ms;
  logic [LOCKOUT_W-1:0]  cur_lockout;
  logic [INTERVAL_W-1:0] cur_interval;
  level_t                prev_lvl;
  logic [LOCKOUT_W-1:0]  lock_left;
  logic [PERIOD_W-1:0]   since_pulse;
  logic                  had_pulse;
  logic [ELAPSED_W-1:0]  elapsed_ms;
  logic [ICOUNT_W-1:0]   pulse_cnt;

  meter_result_t due_results[$];
  logic          levels_to_send[$];

  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned n_pulses = 0;
  int unsigned n_rates = 0;
  int unsigned n_reports = 0;
  int unsigned n_settings = 0;
  int unsigned errors = 0;
  int unsigned src_wait;
  int unsigned snk_wait;
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  longint unsigned cycles = 0;

  function automatic bit meter_sample_result(input logic lvl, output meter_result_t r);
    logic [PERIOD_W:0] grown;
    logic [63:0]       p;
    logic [63:0]       q;
    level_t            now;
    r = '0;
    now = lvl ? LEVEL_HIGH : LEVEL_LOW;
    grown = {1'b0, since_pulse} + cur_sample_ms;
    since_pulse = grown[PERIOD_W] ? '1 : grown[PERIOD_W-1:0];
    elapsed_ms = elapsed_ms + cur_sample_ms;
    if (lock_left != 0) begin
      lock_left = lock_left - 1'b1;
    end else if (now != prev_lvl) begin
      if (now == LEVEL_HIGH) begin
        r.pulse_seen = 1'b1;
        if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
        if (had_pulse) begin
          p = since_pulse;
          r.period_valid = 1'b1;
          r.period_ms = since_pulse;
          q = (p == 0) ? 64'(MS_PER_HOUR) : (64'(MS_PER_HOUR) + p / 2) / p;
          r.pulses_per_hour = q[PPH_W-1:0];
        end
        since_pulse = '0;
        had_pulse = 1'b1;
      end else begin
        lock_left = cur_lockout;
      end
      prev_lvl = now;
    end
    if (elapsed_ms >= cur_interval) begin
      r.report_seen = 1'b1;
      r.interval_count = pulse_cnt;
      pulse_cnt = '0;
      elapsed_ms = (cur_interval == 0) ? '0 : elapsed_ms - cur_interval;
    end
    return r.pulse_seen | r.report_seen;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < MAX_PRINTS)
      $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_level(input logic lvl);
    levels_to_send.push_back(lvl);
    samples_queued++;
  endtask

  task automatic settle();
    while (samples_taken != samples_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    smp_if.valid = 1'b0;
    smp_if.level = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SAMPLE_MS;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      smp_if.valid <= 1'b0;
      src_wait <= 0;
    end else if (!smp_if.valid || smp_if.ready) begin
      if (src_wait != 0) begin
        smp_if.valid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (levels_to_send.size() != 0) begin
        smp_if.valid <= 1'b1;
        smp_if.level <= levels_to_send.pop_front();
        src_wait <= src_idle_on ? $urandom_range(0, 9) : 0;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin : rx_stall
    int unsigned nxt;
    if (rst) begin
      res_if.ready <= 1'b0;
      snk_wait <= 0;
    end else begin
      if (res_if.valid && res_if.ready) nxt = snk_idle_on ? $urandom_range(0, 9) : 0;
      else if (snk_wait != 0) nxt = snk_wait - 1;
      else nxt = 0;
      snk_wait <= nxt;
      res_if.ready <= (nxt == 0);
    end
  end

  // predict on sample acceptance, check on result acceptance
  always @(posedge clk) begin : monitor
    meter_result_t want;
    meter_result_t got;
    if (rst) begin
      cur_sample_ms = SAMPLE_RST;
      cur_lockout   = LOCKOUT_RST;
      cur_interval  = INTERVAL_RST;
      prev_lvl      = LEVEL_UNKNOWN;
      lock_left     = '0;
      since_pulse   = '0;
      had_pulse     = 1'b0;
      elapsed_ms    = '0;
      pulse_cnt     = '0;
      due_results.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_SAMPLE_MS: cur_sample_ms = cfg_if.data[SAMPLE_W-1:0];
          REG_LOCKOUT:   cur_lockout   = cfg_if.data[LOCKOUT_W-1:0];
          REG_INTERVAL:  cur_interval  = cfg_if.data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (smp_if.valid && smp_if.ready) begin
        samples_taken++;
        if (meter_sample_result(smp_if.level, want)) begin
          due_results.push_back(want);
          n_pulses  += want.pulse_seen;
          n_rates   += want.period_valid;
          n_reports += want.report_seen;
        end
      end
      if (res_if.valid && res_if.ready) begin
        got.pulse_seen      = res_if.pulse_seen;
        got.period_valid    = res_if.period_valid;
        got.period_ms       = res_if.period_ms;
        got.pulses_per_hour = res_if.pulses_per_hour;
        got.report_seen     = res_if.report_seen;
        got.interval_count  = res_if.interval_count;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = due_results.pop_front();
          if (got.pulse_seen !== want.pulse_seen)
            report_mismatch("pulse_seen", got.pulse_seen, want.pulse_seen);
          if (got.period_valid !== want.period_valid)
            report_mismatch("period_valid", got.period_valid, want.period_valid);
          if (got.period_ms !== want.period_ms)
            report_mismatch("period_ms", got.period_ms, want.period_ms);
          if (got.pulses_per_hour !== want.pulses_per_hour)
            report_mismatch("pulses_per_hour", got.pulses_per_hour, want.pulses_per_hour);
          if (got.report_seen !== want.report_seen)
            report_mismatch("report_seen", got.report_seen, want.report_seen);
          if (got.interval_count !== want.interval_count)
            report_mismatch("interval_count", got.interval_count, want.interval_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout with %0d of %0d samples taken, %0d results outstanding",
               samples_taken, samples_queued, due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic                  first_lvl;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           ms;
    int unsigned           lock;
    int unsigned           ivl;
    int unsigned           win;
    int unsigned           n;
    int unsigned           start;
    int unsigned           random_items;
    random_items = 0;
    while (rst) @(posedge clk);

    // reset settings: first sample is an edge either way, then default lockout
    first_lvl = 1'($urandom_range(0, 1));
    push_level(first_lvl);
    if (first_lvl) push_level(1'b0);
    for (int i = 0; i < 25; i++) push_level(i % 2 == 0);
    push_level(1'b1);
    settle();

    // zero period and zero interval
    write_reg(REG_SAMPLE_MS, '0);
    write_reg(REG_LOCKOUT, '0);
    write_reg(REG_INTERVAL, '0);
    n_settings++;
    push_level(1'b0);
    push_level(1'b1);
    push_level(1'b0);
    push_level(1'b1);
    settle();

    // 256 ms period lands on a half: 14062.5 rounds up
    write_reg(REG_SAMPLE_MS, 27'd128);
    write_reg(REG_INTERVAL, '1);
    n_settings++;
    push_level(1'b0);
    push_level(1'b1);
    settle();

    // longest sample, then shorten the interval below the elapsed time
    write_reg(REG_SAMPLE_MS, '1);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    n_settings++;
    push_level(1'b0);
    push_level(1'b1);
    settle();
    write_reg(REG_INTERVAL, 27'd300);
    n_settings++;
    push_level(1'b0);
    push_level(1'b1);
    push_level(1'b0);
    settle();

    // long lockout full of flutter, then a long period
    write_reg(REG_LOCKOUT, 27'd300);
    write_reg(REG_INTERVAL, 27'd1000000);
    n_settings++;
    src_idle_on = 1'b0;
    push_level(1'b1);
    push_level(1'b0);
    repeat (300) push_level(1'($urandom_range(0, 1)));
    repeat (20) push_level(1'b0);
    push_level(1'b1);
    settle();

    while (random_items < RANDOM_ITEMS) begin
      ms = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1023);
      lock = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
      case ($urandom_range(0, 5))
        0: ivl = 0;
        1: ivl = $urandom;
        default: ivl = ms * $urandom_range(1, 40) + $urandom_range(0, ms);
      endcase
      data = CFG_DATA_W'($urandom);
      data[SAMPLE_W-1:0] = SAMPLE_W'(ms);
      write_reg(REG_SAMPLE_MS, data);
      data = CFG_DATA_W'($urandom);
      data[LOCKOUT_W-1:0] = LOCKOUT_W'(lock);
      write_reg(REG_LOCKOUT, data);
      write_reg(REG_INTERVAL, CFG_DATA_W'(ivl));
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      n_settings++;
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 110);
      start = samples_queued;
      while (samples_queued - start < n) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) push_level(1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 3)) push_level(1'b1);
          push_level(1'b0);
          win = lock;
          if ($urandom_range(0, 9) == 0 && win != 0) win = win - 1;
          repeat (win) push_level($urandom_range(0, 2) == 0);
          repeat ($urandom_range(0, 2)) push_level(1'b0);
        end
      end
      random_items += samples_queued - start;
      settle();
    end

    $display("Sent %0d samples over %0d register settings, including zero period,",
             samples_taken, n_settings);
    $display("zero interval and long lockout: %0d pulses, %0d rates, %0d reports.",
             n_pulses, n_rates, n_reports);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
